// ===== rtl/mafs_pkg.sv =====
// Shared types, constants and lookup tables for the MPEG audio frame scanner.
`default_nettype none

package mafs_pkg;

  // Stream geometry
  localparam int unsigned HEADER_BYTES   = 4;
  localparam int unsigned HDR_CNT_W      = 2;
  localparam int unsigned COUNT_BITS_DEF = 24;
  localparam int unsigned OUT_COUNT_W    = 24;

  // Field widths
  localparam int unsigned LEN_W  = 11;
  localparam int unsigned KBPS_W = 9;
  localparam int unsigned FREQ_W = 16;
  localparam int unsigned FACT_W = 18;
  localparam int unsigned PROD_W = 26;

  // Shift-subtract divider: one quotient bit per step
  localparam int unsigned DIV_STEPS = LEN_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Header constants
  localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
  localparam logic [11:0] SYNC_WORD     = 12'hFFE;
  localparam logic [3:0]  BRC_FREE      = 4'h0;
  localparam logic [3:0]  BRC_BAD       = 4'hF;
  localparam logic [1:0]  LAYER_RSVD    = 2'd0;
  localparam logic [1:0]  LAYER_I       = 2'd3;
  localparam logic [1:0]  VER_MPEG2     = 2'd0;
  localparam logic [1:0]  VER_MPEG1     = 2'd1;
  localparam logic [1:0]  VER_MPEG25    = 2'd2;
  localparam logic [LEN_W-1:0] HDR_LEN  = LEN_W'(HEADER_BYTES);
  localparam logic [FACT_W-1:0] FACT_L1_M2 = FACT_W'(24000);
  localparam logic [FACT_W-1:0] FACT_L1_M1 = FACT_W'(48000);
  localparam logic [FACT_W-1:0] FACT_LX_M2 = FACT_W'(72000);
  localparam logic [FACT_W-1:0] FACT_LX_M1 = FACT_W'(144000);

  // Result kinds
  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic              layer1;
    logic              mpeg1;
    logic [KBPS_W-1:0] kbps;
    logic [FREQ_W-1:0] freq;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [LEN_W-1:0] quot;
  } div_rsp_t;

  // Sampling frequency in Hz; reserved code reads as 50000
  function automatic logic [FREQ_W-1:0] freq_hz(input logic [1:0] ver,
                                                input logic [1:0] fq);
    logic [FREQ_W-1:0] f;
    f = FREQ_W'(50000);
    unique case (fq)
      2'd0: begin
        f = (ver == VER_MPEG1) ? FREQ_W'(44100) :
            (ver == VER_MPEG2) ? FREQ_W'(22050) : FREQ_W'(11025);
      end
      2'd1: begin
        f = (ver == VER_MPEG1) ? FREQ_W'(48000) :
            (ver == VER_MPEG2) ? FREQ_W'(24000) : FREQ_W'(12000);
      end
      2'd2: begin
        f = (ver == VER_MPEG1) ? FREQ_W'(32000) :
            (ver == VER_MPEG2) ? FREQ_W'(16000) : FREQ_W'(8000);
      end
      default: f = FREQ_W'(50000);
    endcase
    return f;
  endfunction

  // Bitrate in kbps by version class, layer bits and code (1..14)
  function automatic logic [KBPS_W-1:0] kbps_lookup(input logic       mpeg1,
                                                    input logic [1:0] layer,
                                                    input logic [3:0] brc);
    logic [KBPS_W-1:0] k;
    k = '0;
    if (mpeg1) begin
      if (layer == 2'd3) begin
        unique case (brc)
          4'd1: k = 9'd32;   4'd2: k = 9'd64;   4'd3: k = 9'd96;
          4'd4: k = 9'd128;  4'd5: k = 9'd160;  4'd6: k = 9'd192;
          4'd7: k = 9'd224;  4'd8: k = 9'd256;  4'd9: k = 9'd288;
          4'd10: k = 9'd320; 4'd11: k = 9'd352; 4'd12: k = 9'd384;
          4'd13: k = 9'd416; 4'd14: k = 9'd448;
          default: k = '0;
        endcase
      end else if (layer == 2'd2) begin
        unique case (brc)
          4'd1: k = 9'd32;   4'd2: k = 9'd48;   4'd3: k = 9'd56;
          4'd4: k = 9'd64;   4'd5: k = 9'd80;   4'd6: k = 9'd96;
          4'd7: k = 9'd112;  4'd8: k = 9'd128;  4'd9: k = 9'd160;
          4'd10: k = 9'd192; 4'd11: k = 9'd224; 4'd12: k = 9'd256;
          4'd13: k = 9'd320; 4'd14: k = 9'd384;
          default: k = '0;
        endcase
      end else begin
        unique case (brc)
          4'd1: k = 9'd32;   4'd2: k = 9'd40;   4'd3: k = 9'd48;
          4'd4: k = 9'd56;   4'd5: k = 9'd64;   4'd6: k = 9'd80;
          4'd7: k = 9'd96;   4'd8: k = 9'd112;  4'd9: k = 9'd128;
          4'd10: k = 9'd160; 4'd11: k = 9'd192; 4'd12: k = 9'd224;
          4'd13: k = 9'd256; 4'd14: k = 9'd320;
          default: k = '0;
        endcase
      end
    end else begin
      if (layer == 2'd3) begin
        unique case (brc)
          4'd1: k = 9'd32;   4'd2: k = 9'd48;   4'd3: k = 9'd56;
          4'd4: k = 9'd64;   4'd5: k = 9'd80;   4'd6: k = 9'd96;
          4'd7: k = 9'd112;  4'd8: k = 9'd128;  4'd9: k = 9'd144;
          4'd10: k = 9'd160; 4'd11: k = 9'd176; 4'd12: k = 9'd192;
          4'd13: k = 9'd224; 4'd14: k = 9'd256;
          default: k = '0;
        endcase
      end else begin
        unique case (brc)
          4'd1: k = 9'd8;    4'd2: k = 9'd16;   4'd3: k = 9'd24;
          4'd4: k = 9'd32;   4'd5: k = 9'd40;   4'd6: k = 9'd48;
          4'd7: k = 9'd56;   4'd8: k = 9'd64;   4'd9: k = 9'd80;
          4'd10: k = 9'd96;  4'd11: k = 9'd112; 4'd12: k = 9'd128;
          4'd13: k = 9'd144; 4'd14: k = 9'd160;
          default: k = '0;
        endcase
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mafs_apb_regs.sv =====
// APB register file: holds the minimum accepted frame length.
`default_nettype none

module mafs_apb_regs (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready,
  output logic      [mafs_pkg::LEN_W-1:0] min_frame_bytes_o
);

  localparam logic [mafs_pkg::LEN_W-1:0] MIN_FRAME_RST = mafs_pkg::LEN_W'(21);

  logic [mafs_pkg::LEN_W-1:0] min_frame_q, min_frame_d;
  logic                       wr_en;
  logic                       sel_min;

  // Only word 0 is implemented
  assign sel_min = (paddr[2] == 1'b0);
  assign wr_en   = psel & penable & pwrite & sel_min;
  assign pready  = 1'b1;

  assign min_frame_d = wr_en ? pwdata[mafs_pkg::LEN_W-1:0] : min_frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_frame_q <= MIN_FRAME_RST;
    end else begin
      min_frame_q <= min_frame_d;
    end
  end

  // Read back
  assign prdata = sel_min ? 32'(min_frame_q) : 32'd0;

  assign min_frame_bytes_o = min_frame_q;

endmodule

`default_nettype wire

// ===== rtl/mafs_divider.sv =====
// Frame length unit: one multiply, then a shift-subtract divide, one bit a cycle.
`default_nettype none

module mafs_divider (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mafs_pkg::div_req_t  req_i,
  output mafs_pkg::div_rsp_t       rsp_o
);

  localparam int unsigned LW = mafs_pkg::LEN_W;
  localparam int unsigned FW = mafs_pkg::FREQ_W;
  localparam int unsigned PW = mafs_pkg::PROD_W;

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_MUL  = 3'b010,
    D_DIV  = 3'b100
  } div_state_e;

  div_state_e                      state_q, state_d;
  logic [mafs_pkg::DIV_CNT_W-1:0]  step_q, step_d;
  logic                            done_q, done_d;
  logic [FW-1:0]                   rem_q, rem_d;
  logic [LW-1:0]                   low_q, low_d;
  logic [mafs_pkg::FACT_W-1:0]     factor;
  logic [PW:0]                     prod;
  logic [FW:0]                     trial;
  logic [FW:0]                     diff;
  logic                            ge;

  // Layer and version scale factor
  always_comb begin
    unique case ({req_i.layer1, req_i.mpeg1})
      2'b11:   factor = mafs_pkg::FACT_L1_M1;
      2'b10:   factor = mafs_pkg::FACT_L1_M2;
      2'b01:   factor = mafs_pkg::FACT_LX_M1;
      default: factor = mafs_pkg::FACT_LX_M2;
    endcase
  end

  assign prod = (PW + 1)'(factor) * (PW + 1)'(req_i.kbps);

  // One restoring step
  assign trial = {rem_q, low_q[LW-1]};
  assign diff  = trial - {1'b0, req_i.freq};
  assign ge    = (trial >= {1'b0, req_i.freq});

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    done_d  = done_q;
    rem_d   = rem_q;
    low_d   = low_q;
    unique case (state_q)
      D_IDLE: begin
        if (req_i.start) begin
          state_d = D_MUL;
          done_d  = 1'b0;
        end
      end
      D_MUL: begin
        // Quotient fits LW bits, so the top bits start below the divisor
        rem_d   = FW'(prod[PW-1:LW]);
        low_d   = prod[LW-1:0];
        step_d  = '0;
        state_d = D_DIV;
      end
      D_DIV: begin
        rem_d = ge ? diff[FW-1:0] : trial[FW-1:0];
        low_d = {low_q[LW-2:0], ge};
        if (step_q == mafs_pkg::DIV_CNT_W'(mafs_pkg::DIV_STEPS - 1)) begin
          state_d = D_IDLE;
          done_d  = 1'b1;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = low_q;

endmodule

`default_nettype wire

// ===== rtl/mpeg_audio_frame_scanner_top.sv =====
// Top level of the MPEG audio frame scanner: byte sequencer, stream state, result register.
//
//  Channel | Direction | Handshake              | Payload
//  in      | sink      | in_valid_i/in_ready_o  | data_byte, end_of_data
//  out     | source    | out_valid_o/out_ready_i| kind .. last (12 fields)
//  cfg     | APB slave | psel/penable/pready    | min_frame_bytes at offset 0
//
// Most bytes are taken without a stall. A fourth byte that closes a well-formed header
// holds the input off while the divider multiplies and runs its eleven divide steps,
// the sequencer sees the divider finish and the length is checked. end_of_data adds a
// summary step. Results wait in a one-entry output register; while it is still
// full the header or summary step waits and the input stays stalled.
// Reset is asynchronous, no clearing pass.
`default_nettype none

module mpeg_audio_frame_scanner_top #(
  parameter int unsigned COUNT_BITS = mafs_pkg::COUNT_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Byte input
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_data_byte_i,
  input  wire logic        in_end_of_data_i,
  // Result output
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             out_kind_o,
  output logic [1:0]       out_version_o,
  output logic [1:0]       out_layer_code_o,
  output logic [3:0]       out_bitrate_index_o,
  output logic [8:0]       out_bitrate_kbps_o,
  output logic [1:0]       out_freq_index_o,
  output logic             out_padding_o,
  output logic [10:0]      out_frame_size_o,
  output logic             out_resynced_o,
  output logic [23:0]      out_frame_count_o,
  output logic [23:0]      out_bad_frame_count_o,
  output logic             out_last_o,
  // Configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int unsigned LW = mafs_pkg::LEN_W;
  localparam int unsigned CW = mafs_pkg::HDR_CNT_W;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'b001,
    PH_GATHER = 3'b010,
    PH_BODY   = 3'b100
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_HDR  = 4'b0100,
    S_SUM  = 4'b1000
  } seq_state_e;

  // Control state
  seq_state_e            state_q, state_d;
  phase_e                phase_q, phase_d;
  logic [23:0]           hdr_q, hdr_d;
  logic [CW-1:0]         hcnt_q, hcnt_d;
  logic [LW-1:0]         skip_q, skip_d;
  logic                  skipped_q, skipped_d;
  logic [COUNT_BITS-1:0] frames_q, frames_d;
  logic [COUNT_BITS-1:0] bad_q, bad_d;
  logic                  eod_q, eod_d;
  logic                  out_valid_q, out_valid_d;

  // Decoded header held for the divider and the result
  logic [1:0]            hd_ver_q;
  logic [1:0]            hd_layer_q;
  logic [3:0]            hd_brc_q;
  logic [1:0]            hd_fq_q;
  logic                  hd_pad_q;
  logic [8:0]            hd_kbps_q;
  logic                  hd_load;

  // Result register
  logic                  o_kind_q;
  logic [1:0]            o_ver_q;
  logic [1:0]            o_layer_q;
  logic [3:0]            o_brc_q;
  logic [8:0]            o_kbps_q;
  logic [1:0]            o_fq_q;
  logic                  o_pad_q;
  logic [LW-1:0]         o_len_q;
  logic                  o_res_q;
  logic [23:0]           o_frames_q;
  logic [23:0]           o_bad_q;
  logic                  o_last_q;
  logic                  push_hdr;
  logic                  push_sum;

  logic                  in_fire;
  logic                  slot_free;
  logic [LW-1:0]         min_frame;
  mafs_pkg::div_req_t    div_req;
  mafs_pkg::div_rsp_t    div_rsp;

  // Header decode from the three gathered bytes
  logic [7:0]            b0, b1, b2;
  logic [11:0]           sync;
  logic [1:0]            dec_ver;
  logic [1:0]            dec_layer;
  logic [3:0]            dec_brc;
  logic                  dec_ok;

  // Length check
  logic [LW-1:0]         len;
  logic                  len_ok;
  logic [COUNT_BITS-1:0] frames_inc;
  logic [COUNT_BITS-1:0] bad_inc;
  logic [COUNT_BITS-1:0] bad_sum;

  assign b0        = hdr_q[23:16];
  assign b1        = hdr_q[15:8];
  assign b2        = hdr_q[7:0];
  assign sync      = {b0, b1[7:5], 1'b0};
  assign dec_ver   = b1[4] ? {1'b0, b1[3]} : mafs_pkg::VER_MPEG25;
  assign dec_layer = b1[2:1];
  assign dec_brc   = b2[7:4];
  assign dec_ok    = (sync == mafs_pkg::SYNC_WORD) && (dec_layer != mafs_pkg::LAYER_RSVD) &&
                     (dec_brc != mafs_pkg::BRC_FREE) && (dec_brc != mafs_pkg::BRC_BAD);

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign slot_free  = ~out_valid_q | out_ready_i;

  assign len        = div_rsp.quot + LW'(hd_pad_q);
  assign len_ok     = (len >= min_frame);
  assign frames_inc = (frames_q == '1) ? frames_q : frames_q + 1'b1;
  assign bad_inc    = (bad_q == '1) ? bad_q : bad_q + 1'b1;
  assign bad_sum    = ((phase_q == PH_GATHER) || skipped_q) ? bad_inc : bad_q;

  // Divider request from the held header
  assign div_req.start  = hd_load & dec_ok;
  assign div_req.layer1 = (hd_layer_q == mafs_pkg::LAYER_I);
  assign div_req.mpeg1  = hd_ver_q[0];
  assign div_req.kbps   = hd_kbps_q;
  assign div_req.freq   = mafs_pkg::freq_hz(hd_ver_q, hd_fq_q);

  // Sequencer and stream state
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    hdr_d       = hdr_q;
    hcnt_d      = hcnt_q;
    skip_d      = skip_q;
    skipped_d   = skipped_q;
    frames_d    = frames_q;
    bad_d       = bad_q;
    eod_d       = eod_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    hd_load     = 1'b0;
    push_hdr    = 1'b0;
    push_sum    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          eod_d = in_end_of_data_i;
          if (in_end_of_data_i) begin
            state_d = S_SUM;
          end
          unique case (phase_q)
            PH_HUNT: begin
              if (in_data_byte_i == mafs_pkg::SYNC_BYTE) begin
                hdr_d   = {16'd0, in_data_byte_i};
                hcnt_d  = CW'(1);
                phase_d = PH_GATHER;
              end else begin
                skipped_d = 1'b1;
              end
            end
            PH_GATHER: begin
              if (hcnt_q < CW'(mafs_pkg::HEADER_BYTES - 1)) begin
                hdr_d  = {hdr_q[15:0], in_data_byte_i};
                hcnt_d = hcnt_q + 1'b1;
              end else begin
                // Fourth byte: header complete
                hd_load = 1'b1;
                hdr_d   = '0;
                hcnt_d  = '0;
                phase_d = PH_HUNT;
                if (dec_ok) begin
                  state_d = S_CALC;
                end else begin
                  skipped_d = 1'b1;
                end
              end
            end
            PH_BODY: begin
              skip_d = skip_q - 1'b1;
              if (skip_q == LW'(1)) begin
                phase_d = PH_HUNT;
              end
            end
            default: phase_d = PH_HUNT;
          endcase
        end
      end
      S_CALC: begin
        if (div_rsp.done) begin
          state_d = S_HDR;
        end
      end
      S_HDR: begin
        if (!len_ok) begin
          skipped_d = 1'b1;
          phase_d   = PH_HUNT;
          state_d   = eod_q ? S_SUM : S_IDLE;
        end else if (slot_free) begin
          push_hdr    = 1'b1;
          out_valid_d = 1'b1;
          frames_d    = frames_inc;
          if (skipped_q) begin
            bad_d = bad_inc;
          end
          skipped_d = 1'b0;
          skip_d    = (len > mafs_pkg::HDR_LEN) ? len - mafs_pkg::HDR_LEN : '0;
          phase_d   = (len > mafs_pkg::HDR_LEN) ? PH_BODY : PH_HUNT;
          state_d   = eod_q ? S_SUM : S_IDLE;
        end
      end
      S_SUM: begin
        if (slot_free) begin
          // Summary, then back to a fresh stream
          push_sum    = 1'b1;
          out_valid_d = 1'b1;
          phase_d     = PH_HUNT;
          hdr_d       = '0;
          hcnt_d      = '0;
          skip_d      = '0;
          skipped_d   = 1'b0;
          frames_d    = '0;
          bad_d       = '0;
          eod_d       = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_HUNT;
      hdr_q       <= '0;
      hcnt_q      <= '0;
      skip_q      <= '0;
      skipped_q   <= 1'b0;
      frames_q    <= '0;
      bad_q       <= '0;
      eod_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      hdr_q       <= hdr_d;
      hcnt_q      <= hcnt_d;
      skip_q      <= skip_d;
      skipped_q   <= skipped_d;
      frames_q    <= frames_d;
      bad_q       <= bad_d;
      eod_q       <= eod_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Header field capture
  always_ff @(posedge clk_i) begin
    if (hd_load) begin
      hd_ver_q   <= dec_ver;
      hd_layer_q <= dec_layer;
      hd_brc_q   <= dec_brc;
      hd_fq_q    <= b2[3:2];
      hd_pad_q   <= b2[1];
      hd_kbps_q  <= mafs_pkg::kbps_lookup(dec_ver[0], dec_layer, dec_brc);
    end
  end

  // Result register load
  always_ff @(posedge clk_i) begin
    if (push_hdr) begin
      o_kind_q   <= mafs_pkg::KIND_HEADER;
      o_ver_q    <= hd_ver_q;
      o_layer_q  <= hd_layer_q;
      o_brc_q    <= hd_brc_q;
      o_kbps_q   <= hd_kbps_q;
      o_fq_q     <= hd_fq_q;
      o_pad_q    <= hd_pad_q;
      o_len_q    <= len;
      o_res_q    <= skipped_q;
      o_frames_q <= 24'(frames_inc);
      o_bad_q    <= skipped_q ? 24'(bad_inc) : 24'(bad_q);
      o_last_q   <= 1'b0;
    end else if (push_sum) begin
      o_kind_q   <= mafs_pkg::KIND_SUMMARY;
      o_ver_q    <= '0;
      o_layer_q  <= '0;
      o_brc_q    <= '0;
      o_kbps_q   <= '0;
      o_fq_q     <= '0;
      o_pad_q    <= 1'b0;
      o_len_q    <= '0;
      o_res_q    <= 1'b0;
      o_frames_q <= 24'(frames_q);
      o_bad_q    <= 24'(bad_sum);
      o_last_q   <= 1'b1;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_kind_o            = o_kind_q;
  assign out_version_o         = o_ver_q;
  assign out_layer_code_o      = o_layer_q;
  assign out_bitrate_index_o   = o_brc_q;
  assign out_bitrate_kbps_o    = o_kbps_q;
  assign out_freq_index_o      = o_fq_q;
  assign out_padding_o         = o_pad_q;
  assign out_frame_size_o      = o_len_q;
  assign out_resynced_o        = o_res_q;
  assign out_frame_count_o     = o_frames_q;
  assign out_bad_frame_count_o = o_bad_q;
  assign out_last_o            = o_last_q;

  mafs_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  mafs_apb_regs u_regs (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .min_frame_bytes_o (min_frame)
  );

endmodule

`default_nettype wire

// ===== rtl/mafs_checker.sv =====
// Port-level checks on the frame scanner, bound to the top level.
`default_nettype none

module mafs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        in_end_of_data_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        out_kind_o,
  input wire logic [1:0]  out_version_o,
  input wire logic [10:0] out_frame_size_o,
  input wire logic        out_last_o,
  input wire logic        pready
);

  // Summary transfers carry last and an empty header part
  a_summary_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o |-> out_last_o && out_frame_size_o == 11'd0 &&
                                  out_version_o == 2'd0)
    else $error("summary result malformed");

  // Header transfers never carry last and always have a length
  a_header_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_kind_o |-> !out_last_o && out_frame_size_o != 11'd0)
    else $error("header result malformed");

  // Taking the final byte always makes the input busy for the summary step
  a_eod_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_end_of_data_i |=> !in_ready_o)
    else $error("input taken right after end of data");

  // A result held back by the sink keeps its kind
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_kind_o))
    else $error("stalled result changed");

  // Config port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind mpeg_audio_frame_scanner_top mafs_checker u_mafs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .in_end_of_data_i (in_end_of_data_i),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .out_kind_o       (out_kind_o),
  .out_version_o    (out_version_o),
  .out_frame_size_o (out_frame_size_o),
  .out_last_o       (out_last_o),
  .pready           (pready)
);

`default_nettype wire
